// File: rtl/vnorm_pkg.sv
package vnorm_pkg;

    // Field widths of one transaction.
    localparam int COMP_BITS = 16;
    localparam int MAG_BITS  = COMP_BITS + 1;
    localparam int SQ_BITS   = 2 * COMP_BITS;
    localparam int SUM_BITS  = SQ_BITS + 1;
    localparam int NUM_COMPS = 4;

    // Square root resolves one result bit per stage; the divider one quotient bit.
    localparam int SQRT_STEPS = MAG_BITS;
    localparam int DIV_STEPS  = COMP_BITS;
    localparam int NUM_BITS   = 2 * COMP_BITS - 1;

    localparam int DIM_BITS = 3;
    localparam logic [DIM_BITS-1:0] DIM_RESET = 3'd3;
    localparam logic [DIM_BITS-1:0] DIM_MIN   = 3'd2;
    localparam logic [DIM_BITS-1:0] DIM_MAX   = 3'd4;

    typedef logic [DIM_BITS-1:0] dim_t;

    typedef struct packed {
        logic signed [COMP_BITS-1:0] comp_x;
        logic signed [COMP_BITS-1:0] comp_y;
        logic signed [COMP_BITS-1:0] comp_z;
        logic signed [COMP_BITS-1:0] comp_w;
    } vec_in_t;

    typedef struct packed {
        logic signed [COMP_BITS-1:0] norm_x;
        logic signed [COMP_BITS-1:0] norm_y;
        logic signed [COMP_BITS-1:0] norm_z;
        logic signed [COMP_BITS-1:0] norm_w;
        logic [MAG_BITS-1:0]         magnitude;
        logic                        zero_vector;
    } vec_out_t;

endpackage

// File: rtl/vnorm_div.sv
module vnorm_div (
    input  logic                             clk,
    input  logic [vnorm_pkg::COMP_BITS-1:0]  num,
    input  logic                             neg,
    input  logic                             kill,
    input  logic [vnorm_pkg::MAG_BITS-1:0]   divisor,
    output logic signed [vnorm_pkg::COMP_BITS-1:0] quotient
);
    import vnorm_pkg::*;

    localparam int CMP_BITS = NUM_BITS + 2;

    logic [NUM_BITS-1:0]  rem_reg  [0:DIV_STEPS];
    logic [COMP_BITS-1:0] quo_reg  [0:DIV_STEPS];
    logic [MAG_BITS-1:0]  dvs_reg  [0:DIV_STEPS];
    logic                 neg_reg  [0:DIV_STEPS];
    logic                 kill_reg [0:DIV_STEPS];
    logic signed [COMP_BITS-1:0] quotient_reg;
    logic signed [COMP_BITS-1:0] quotient_next;

    // Entry stage: the numerator is the magnitude of the component scaled to full scale.
    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= NUM_BITS'({num, {(COMP_BITS-1){1'b0}}});
        quo_reg[0]  <= '0;
        dvs_reg[0]  <= divisor;
        neg_reg[0]  <= neg;
        kill_reg[0] <= kill;
    end

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        localparam int BIT = DIV_STEPS - 1 - k;
        logic [CMP_BITS-1:0] shifted;
        logic                fits;

        assign shifted = CMP_BITS'(dvs_reg[k]) << BIT;
        assign fits    = CMP_BITS'(rem_reg[k]) >= shifted;

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= fits ? NUM_BITS'(CMP_BITS'(rem_reg[k]) - shifted) : rem_reg[k];
            quo_reg[k+1]  <= quo_reg[k] | (COMP_BITS'(fits) << BIT);
            dvs_reg[k+1]  <= dvs_reg[k];
            neg_reg[k+1]  <= neg_reg[k];
            kill_reg[k+1] <= kill_reg[k];
        end
    end

    // Zero the quotient for a zero vector, else apply the sign; a positive quotient saturates to the fractional range.
    always_comb
    begin
        if (kill_reg[DIV_STEPS])
            quotient_next = '0;
        else if (neg_reg[DIV_STEPS])
            quotient_next = COMP_BITS'(~quo_reg[DIV_STEPS] + 1'b1);
        else if (quo_reg[DIV_STEPS][COMP_BITS-1])
            quotient_next = {1'b0, {(COMP_BITS-1){1'b1}}};
        else
            quotient_next = quo_reg[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        quotient_reg <= quotient_next;
    end

    assign quotient = quotient_reg;

endmodule

// File: rtl/vector_normalize_unit.sv
// Vector normalisation unit.
// A transaction on the operand channel is taken at a rising edge where start
// is high and busy is low. busy is held low: the block is fully pipelined and
// accepts one vector in every cycle, with no dependence between vectors.
// Each vector yields one result after passing three registers for input,
// squaring and summing, 18 for the square root (entry register and one root
// bit per stage) and 18 for division (entry register, one quotient bit per
// stage and the sign and saturation register). done is high for exactly one
// cycle with the result; the receiver cannot stall, so nothing is held back.
// The dimension register is written over cfg_valid/cfg_ready; cfg_ready is
// always high. Write it only while no transaction is in flight.
// Reset clears the pipeline valid bits, so done stays low until a new vector
// has passed through, and sets the dimension to 3.
// Dimensions below 2 act as 2, above 4 act as 4. A vector whose used
// components are all zero gives zero_vector with zero magnitude and outputs.
module vector_normalize_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  vnorm_pkg::vec_in_t         operand,
    output logic                       done,
    output vnorm_pkg::vec_out_t        result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  vnorm_pkg::dim_t            cfg_data
);
    import vnorm_pkg::*;

    localparam int DIV_LAT = DIV_STEPS + 2;
    localparam int LATENCY = 3 + SQRT_STEPS + 1 + DIV_LAT;
    localparam int CMP_BITS = SUM_BITS + 2;

    dim_t dim_reg;
    logic accept;

    logic                 v0_reg;
    logic [COMP_BITS-1:0] comp0_reg [NUM_COMPS];

    logic                 v1_reg;
    logic [COMP_BITS-1:0] abs1_reg [NUM_COMPS];
    logic                 neg1_reg [NUM_COMPS];
    logic [SQ_BITS-1:0]   sq1_reg  [NUM_COMPS];

    logic                 v2_reg;
    logic [COMP_BITS-1:0] abs2_reg [NUM_COMPS];
    logic                 neg2_reg [NUM_COMPS];
    logic [SUM_BITS-1:0]  sum2_reg;

    logic                 sv_reg   [0:SQRT_STEPS];
    logic [SUM_BITS-1:0]  rem_reg  [0:SQRT_STEPS];
    logic [MAG_BITS-1:0]  root_reg [0:SQRT_STEPS];
    logic                 zero_reg [0:SQRT_STEPS];
    logic [COMP_BITS-1:0] sabs_reg [0:SQRT_STEPS][NUM_COMPS];
    logic                 sneg_reg [0:SQRT_STEPS][NUM_COMPS];

    logic                 dv_reg   [DIV_LAT];
    logic [MAG_BITS-1:0]  dmag_reg [DIV_LAT];
    logic                 dz_reg   [DIV_LAT];
    logic signed [COMP_BITS-1:0] quo [NUM_COMPS];

    logic [COMP_BITS-1:0] comp_next [NUM_COMPS];
    logic [2:0]           used;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Dimension register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dim_reg <= DIM_RESET;
        else if (cfg_valid && cfg_ready)
            dim_reg <= cfg_data;
    end

    // Clamp the dimension and zero the unused components.
    always_comb
    begin
        if (dim_reg < DIM_MIN)
            used = DIM_MIN;
        else if (dim_reg > DIM_MAX)
            used = DIM_MAX;
        else
            used = dim_reg;
        comp_next[0] = operand.comp_x;
        comp_next[1] = operand.comp_y;
        comp_next[2] = (used >= 3'd3) ? operand.comp_z : '0;
        comp_next[3] = (used == DIM_MAX) ? operand.comp_w : '0;
    end

    // Valid bits of the front stages and the square root.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            sv_reg[0] <= 1'b0;
        end
        else
        begin
            v0_reg    <= accept;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            sv_reg[0] <= v2_reg;
        end
    end

    // Input register, absolute value with squaring, then the sum of squares.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_COMPS; i++)
        begin
            comp0_reg[i] <= comp_next[i];
            neg1_reg[i]  <= comp0_reg[i][COMP_BITS-1];
            abs1_reg[i]  <= comp0_reg[i][COMP_BITS-1] ?
                            COMP_BITS'(~comp0_reg[i] + 1'b1) : comp0_reg[i];
            sq1_reg[i]   <= SQ_BITS'(comp0_reg[i][COMP_BITS-1] ?
                            COMP_BITS'(~comp0_reg[i] + 1'b1) : comp0_reg[i]) *
                            SQ_BITS'(comp0_reg[i][COMP_BITS-1] ?
                            COMP_BITS'(~comp0_reg[i] + 1'b1) : comp0_reg[i]);
            abs2_reg[i]  <= abs1_reg[i];
            neg2_reg[i]  <= neg1_reg[i];
            sabs_reg[0][i] <= abs2_reg[i];
            sneg_reg[0][i] <= neg2_reg[i];
        end
        sum2_reg    <= SUM_BITS'(sq1_reg[0]) + SUM_BITS'(sq1_reg[1]) +
                       SUM_BITS'(sq1_reg[2]) + SUM_BITS'(sq1_reg[3]);
        rem_reg[0]  <= sum2_reg;
        root_reg[0] <= '0;
        zero_reg[0] <= (sum2_reg == '0);
    end

    // Square root, one root bit per stage from the top.
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam int BIT = SQRT_STEPS - 1 - k;
        logic [CMP_BITS-1:0] trial;
        logic                fits;

        assign trial = (CMP_BITS'(root_reg[k]) << (BIT + 1)) + (CMP_BITS'(1) << (2 * BIT));
        assign fits  = CMP_BITS'(rem_reg[k]) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_reg[k+1] <= 1'b0;
            else
                sv_reg[k+1] <= sv_reg[k];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= fits ? SUM_BITS'(CMP_BITS'(rem_reg[k]) - trial) : rem_reg[k];
            root_reg[k+1] <= root_reg[k] | (MAG_BITS'(fits) << BIT);
            zero_reg[k+1] <= zero_reg[k];
            for (int i = 0; i < NUM_COMPS; i++)
            begin
                sabs_reg[k+1][i] <= sabs_reg[k][i];
                sneg_reg[k+1][i] <= sneg_reg[k][i];
            end
        end
    end

    // Division lanes, one for each component.
    for (genvar c = 0; c < NUM_COMPS; c++) begin : g_lane
        vnorm_div u_div (
            .clk      (clk),
            .num      (sabs_reg[SQRT_STEPS][c]),
            .neg      (sneg_reg[SQRT_STEPS][c]),
            .kill     (zero_reg[SQRT_STEPS]),
            .divisor  (root_reg[SQRT_STEPS]),
            .quotient (quo[c])
        );
    end

    // Valid, magnitude and zero flag travel alongside the divider.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < DIV_LAT; j++)
                dv_reg[j] <= 1'b0;
        end
        else
        begin
            dv_reg[0] <= sv_reg[SQRT_STEPS];
            for (int j = 1; j < DIV_LAT; j++)
                dv_reg[j] <= dv_reg[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        dmag_reg[0] <= root_reg[SQRT_STEPS];
        dz_reg[0]   <= zero_reg[SQRT_STEPS];
        for (int j = 1; j < DIV_LAT; j++)
        begin
            dmag_reg[j] <= dmag_reg[j-1];
            dz_reg[j]   <= dz_reg[j-1];
        end
    end

    // Result transaction.
    assign done               = dv_reg[DIV_LAT-1];
    assign result.norm_x      = quo[0];
    assign result.norm_y      = quo[1];
    assign result.norm_z      = quo[2];
    assign result.norm_w      = quo[3];
    assign result.magnitude   = dmag_reg[DIV_LAT-1];
    assign result.zero_vector = dz_reg[DIV_LAT-1];

`ifndef SYNTH
    // Every accepted transaction comes out after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("result missing after pipeline latency");

    // No result appears without a matching transaction at the input.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without an accepted transaction");

    // A zero vector reports zero magnitude and zero components.
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.zero_vector) |-> (result.magnitude == '0 &&
        result.norm_x == '0 && result.norm_y == '0 &&
        result.norm_z == '0 && result.norm_w == '0))
        else $error("zero vector with non-zero outputs");

    // A non-zero vector always has a non-zero magnitude.
    a_mag_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.zero_vector) |-> (result.magnitude != '0))
        else $error("non-zero vector with zero magnitude");
`endif

endmodule

// File: verif/tb.sv
module tb;
    import vnorm_pkg::*;

    localparam int LATENCY   = 39;
    localparam int IDLE_MAX  = 18;
    localparam int WDOG_MAX  = 4000;
    localparam int N_RANDOM  = 1400;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    vec_in_t  operand;
    logic     done;
    vec_out_t result;
    logic     cfg_valid;
    logic     cfg_ready;
    dim_t     cfg_data;

    vector_normalize_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operand   (operand),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // One row of the directed table. When has_exp is set the row's result is typed in.
    typedef struct {
        dim_t     dim;
        vec_in_t  vec;
        bit       has_exp;
        vec_out_t exp_res;
    } dir_row_t;

    dim_t     dim_shadow;
    vec_out_t norm_queue[$];
    int       error_count;
    int       idle_cycles;

    // Clock.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Integer square root, rounded down.
    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Expected normalised vector for the current dimension.
    function automatic vec_out_t normalize_vec(dim_t dim, vec_in_t v);
        vec_out_t        o;
        longint          c[4];
        longint          q;
        longint unsigned sum;
        longint unsigned mag;
        int              used;
        used = (dim < DIM_MIN) ? 2 : (dim > DIM_MAX) ? 4 : int'(dim);
        c[0] = v.comp_x;
        c[1] = v.comp_y;
        c[2] = (used > 2) ? longint'(v.comp_z) : 0;
        c[3] = (used > 3) ? longint'(v.comp_w) : 0;
        sum = 0;
        for (int i = 0; i < 4; i++)
            sum += c[i] * c[i];
        o = '0;
        if (sum == 0)
        begin
            o.zero_vector = 1'b1;
            return o;
        end
        mag = isqrt(sum);
        for (int i = 0; i < 4; i++)
        begin
            q = (c[i] * 32768) / longint'(mag);
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            c[i] = q;
        end
        o.norm_x    = c[0][15:0];
        o.norm_y    = c[1][15:0];
        o.norm_z    = c[2][15:0];
        o.norm_w    = c[3][15:0];
        o.magnitude = mag[MAG_BITS-1:0];
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Compare every result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        vec_out_t want;
        if (rst_n && done)
        begin
            if (norm_queue.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                want = norm_queue.pop_front();
                if (result.norm_x != want.norm_x)
                    report_mismatch("norm_x", result.norm_x, want.norm_x);
                if (result.norm_y != want.norm_y)
                    report_mismatch("norm_y", result.norm_y, want.norm_y);
                if (result.norm_z != want.norm_z)
                    report_mismatch("norm_z", result.norm_z, want.norm_z);
                if (result.norm_w != want.norm_w)
                    report_mismatch("norm_w", result.norm_w, want.norm_w);
                if (result.magnitude != want.magnitude)
                    report_mismatch("magnitude", result.magnitude, want.magnitude);
                if (result.zero_vector != want.zero_vector)
                    report_mismatch("zero_vector", result.zero_vector, want.zero_vector);
            end
        end
    end

    // Watchdog on cycles without an accepted transaction, a result or a dimension write.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // Stop sending, then wait until every expected result has arrived.
    task automatic drain();
        start <= 1'b0;
        while (norm_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_dim(dim_t d);
        cfg_valid <= 1'b1;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        dim_shadow = d;
    endtask

    // Present one vector; the expectation is queued at the accepting edge.
    // start stays high after the last vector until the next gap or a drain.
    task automatic send_vec(vec_in_t v, bit has_exp, vec_out_t exp_res, bit gaps);
        int gap;
        gap = gaps ? ((($urandom_range(0, 3) == 0)) ? 0 : $urandom_range(0, IDLE_MAX)) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        operand <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        norm_queue.push_back(has_exp ? exp_res : normalize_vec(dim_shadow, v));
    endtask

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'(signed'($urandom_range(0, 16) - 8));
            3:       return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    dir_row_t dir_table[$];

    function automatic vec_out_t mk_out(int x, int y, int z, int w, int m, bit zv);
        vec_out_t o;
        o.norm_x = 16'(x);
        o.norm_y = 16'(y);
        o.norm_z = 16'(z);
        o.norm_w = 16'(w);
        o.magnitude = 17'(m);
        o.zero_vector = zv;
        return o;
    endfunction

    function automatic void add_row(dim_t d, int x, int y, int z, int w, bit he, vec_out_t e);
        dir_row_t r;
        r.dim = d;
        r.vec.comp_x = 16'(x);
        r.vec.comp_y = 16'(y);
        r.vec.comp_z = 16'(z);
        r.vec.comp_w = 16'(w);
        r.has_exp = he;
        r.exp_res = e;
        dir_table.push_back(r);
    endfunction

    initial
    begin
        dim_t     d;
        vec_in_t  v;
        vec_out_t none;
        none        = '0;
        rst_n       = 1'b0;
        start       = 1'b0;
        operand     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        error_count = 0;
        idle_cycles = 0;
        dim_shadow  = DIM_RESET;

        // Directed table: reset dimension first, then each dimension setting.
        add_row(DIM_RESET, 0, 0, 0, 0, 1, mk_out(0, 0, 0, 0, 0, 1));
        add_row(DIM_RESET, 5, 0, 0, 9, 1, mk_out(32767, 0, 0, 0, 5, 0));
        add_row(DIM_RESET, 0, -7, 0, 0, 1, mk_out(0, -32768, 0, 0, 7, 0));
        add_row(DIM_RESET, 1, 1, 1, 0, 1, mk_out(32767, 32767, 32767, 0, 1, 0));
        add_row(DIM_RESET, -32768, -32768, -32768, -32768, 0, none);
        add_row(DIM_RESET, 32767, 32767, 32767, 32767, 0, none);
        add_row(3'd2, 0, 0, 7, 7, 1, mk_out(0, 0, 0, 0, 0, 1));
        add_row(3'd2, 3, 4, 100, 100, 1, mk_out(19660, 26214, 0, 0, 5, 0));
        add_row(3'd2, -32768, -32768, 1, 1, 0, none);
        add_row(3'd2, 32767, -32768, 0, 0, 0, none);
        add_row(3'd4, 1, 1, 1, 1, 1, mk_out(16384, 16384, 16384, 16384, 2, 0));
        add_row(3'd4, -32768, -32768, -32768, -32768, 1,
                mk_out(-16384, -16384, -16384, -16384, 65536, 0));
        add_row(3'd4, 0, 0, 0, -1, 1, mk_out(0, 0, 0, -32768, 1, 0));
        add_row(3'd4, 32767, 32767, 32767, 32767, 0, none);
        add_row(3'd0, 0, 0, 5, 5, 1, mk_out(0, 0, 0, 0, 0, 1));
        add_row(3'd1, 3, -4, 9, 9, 0, none);
        add_row(3'd5, 1, 1, 1, 1, 1, mk_out(16384, 16384, 16384, 16384, 2, 0));
        add_row(3'd6, 2, 3, 5, 7, 0, none);
        add_row(3'd7, -1, 2, -3, 4, 0, none);
        add_row(3'd3, 12345, -23456, 31111, 999, 0, none);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part; dimension changes only with the pipeline empty.
        foreach (dir_table[i])
        begin
            if (dir_table[i].dim != dim_shadow)
            begin
                drain();
                write_dim(dir_table[i].dim);
            end
            send_vec(dir_table[i].vec, dir_table[i].has_exp, dir_table[i].exp_res, 0);
        end

        // Random part in phases, each with its own dimension setting.
        for (int ph = 0; ph < 14; ph++)
        begin
            drain();
            d = (ph < 8) ? dim_t'(ph) : dim_t'($urandom_range(0, 7));
            write_dim(d);
            for (int k = 0; k < N_RANDOM / 14; k++)
            begin
                v.comp_x = rand_comp();
                v.comp_y = rand_comp();
                v.comp_z = rand_comp();
                v.comp_w = rand_comp();
                if ($urandom_range(0, 19) == 0)
                    v = '0;
                send_vec(v, 0, none, (ph % 3) != 1);
            end
        end
        drain();

        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// File: files.f
rtl/vnorm_pkg.sv
rtl/vnorm_div.sv
rtl/vector_normalize_unit.sv
verif/tb.sv
